// ----- src/jset_pkg.sv -----
// Shared types, constants and register codes for the Julia set escape-time unit.
package jset_pkg;

	// Grid, fixed-point and counter sizing
	localparam int GRID_SIZE  = 512;
	localparam int FRAC_BITS  = 28;
	localparam int COUNT_BITS = 10;
	localparam int IDX_W      = 9;
	localparam int HUE_W      = (COUNT_BITS > 9) ? COUNT_BITS : 9;
	localparam int CFG_IDX_W  = 4;

	localparam logic [HUE_W-1:0] HUE_TURN   = HUE_W'(360);
	localparam logic [HUE_W-1:0] HUE_SECTOR = HUE_W'(60);
	localparam logic [IDX_W-1:0] GRID_LAST  = IDX_W'(GRID_SIZE - 1);

	// Register reset values
	localparam logic [31:0] RST_C_REAL     = 32'hF4C5_89CE;
	localparam logic [31:0] RST_C_IMAG     = 32'hF9D6_511A;
	localparam logic [9:0]  RST_ITER_LIMIT = 10'd180;
	localparam logic [30:0] RST_ESCAPE     = 31'd536870912;
	localparam logic [31:0] RST_REAL_START = 32'hE666_6666;
	localparam logic [30:0] RST_REAL_STEP  = 31'd1677722;
	localparam logic [31:0] RST_IMAG_START = 32'hECCC_CCCD;
	localparam logic [30:0] RST_IMAG_STEP  = 31'd1258291;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_C_REAL,
		CFG_C_IMAG,
		CFG_ITER_LIMIT,
		CFG_ESCAPE_LIMIT,
		CFG_REAL_START,
		CFG_REAL_STEP,
		CFG_IMAG_START,
		CFG_IMAG_STEP
	} jset_cfg_idx_t;

	// Sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MAP,
		ST_START,
		ST_SQUARE,
		ST_TEST,
		ST_HUE,
		ST_FIN
	} jset_state_t;

	// Hue sectors of sixty degrees each
	typedef enum logic [2:0] {
		SEC_RED,
		SEC_YELLOW,
		SEC_GREEN,
		SEC_CYAN,
		SEC_BLUE,
		SEC_MAGENTA
	} jset_sector_t;

	typedef struct packed {
		logic [IDX_W-1:0] column_index;
		logic [IDX_W-1:0] row_index;
	} jset_req_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [9:0] iteration_count;
		logic       bounded;
	} jset_rsp_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} jset_rgb_t;

	typedef struct packed {
		logic signed [31:0] c_real;
		logic signed [31:0] c_imag;
		logic [9:0]         iteration_limit;
		logic [30:0]        escape_limit;
		logic signed [31:0] real_start;
		logic [30:0]        real_step;
		logic signed [31:0] imag_start;
		logic [30:0]        imag_step;
	} jset_cfg_t;

	typedef struct packed {
		logic signed [31:0] a0;
		logic signed [31:0] b0;
		logic signed [31:0] a1;
		logic signed [31:0] b1;
		logic signed [31:0] a2;
		logic signed [31:0] b2;
	} jset_mul_ops_t;

	typedef struct packed {
		logic signed [63:0] p0;
		logic signed [63:0] p1;
		logic signed [63:0] p2;
	} jset_mul_prod_t;

endpackage

// ----- src/jset_cfg.sv -----
// Configuration register file with reset defaults and index decode.
module jset_cfg (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	input  logic [jset_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]                    cfg_data,
	output jset_pkg::jset_cfg_t            cfg
);

	jset_pkg::jset_cfg_t cfg_q;

	// Load defaults on reset, write one register per transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.c_real          <= jset_pkg::RST_C_REAL;
			cfg_q.c_imag          <= jset_pkg::RST_C_IMAG;
			cfg_q.iteration_limit <= jset_pkg::RST_ITER_LIMIT;
			cfg_q.escape_limit    <= jset_pkg::RST_ESCAPE;
			cfg_q.real_start      <= jset_pkg::RST_REAL_START;
			cfg_q.real_step       <= jset_pkg::RST_REAL_STEP;
			cfg_q.imag_start      <= jset_pkg::RST_IMAG_START;
			cfg_q.imag_step       <= jset_pkg::RST_IMAG_STEP;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				jset_pkg::CFG_C_REAL:       cfg_q.c_real          <= cfg_data;
				jset_pkg::CFG_C_IMAG:       cfg_q.c_imag          <= cfg_data;
				jset_pkg::CFG_ITER_LIMIT:   cfg_q.iteration_limit <= cfg_data[9:0];
				jset_pkg::CFG_ESCAPE_LIMIT: cfg_q.escape_limit    <= cfg_data[30:0];
				jset_pkg::CFG_REAL_START:   cfg_q.real_start      <= cfg_data;
				jset_pkg::CFG_REAL_STEP:    cfg_q.real_step       <= cfg_data[30:0];
				jset_pkg::CFG_IMAG_START:   cfg_q.imag_start      <= cfg_data;
				jset_pkg::CFG_IMAG_STEP:    cfg_q.imag_step       <= cfg_data[30:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ----- src/jset_cmul.sv -----
// Shared multiply unit: three signed 32x32 products, registered.
module jset_cmul (
	input  logic                     clk,
	input  jset_pkg::jset_mul_ops_t  ops,
	output jset_pkg::jset_mul_prod_t prod
);

	jset_pkg::jset_mul_prod_t prod_q;

	// Multiply every cycle; the sequencer reads the products in the next cycle
	always_ff @(posedge clk) begin
		prod_q.p0 <= 64'(ops.a0) * 64'(ops.b0);
		prod_q.p1 <= 64'(ops.a1) * 64'(ops.b1);
		prod_q.p2 <= 64'(ops.a2) * 64'(ops.b2);
	end

	assign prod = prod_q;

endmodule

// ----- src/jset_hue.sv -----
// Hue to RGB colouring at full saturation and value for one sector.
module jset_hue (
	input  jset_pkg::jset_sector_t sector,
	input  logic [5:0]             frac,
	output jset_pkg::jset_rgb_t    rgb
);

	logic [5:0] fall_in;
	logic [9:0] rise_prod;
	logic [9:0] fall_prod;
	logic [7:0] rise;
	logic [7:0] fall;

	// 255/60 equals 17/4, so each ramp is a small multiply and a shift
	assign fall_in   = 6'd60 - frac;
	assign rise_prod = {4'b0, frac} * 10'd17;
	assign fall_prod = {4'b0, fall_in} * 10'd17;
	assign rise      = rise_prod[9:2];
	assign fall      = fall_prod[9:2];

	// Pick the channel pattern for the sector
	always_comb begin
		unique case (sector)
			jset_pkg::SEC_RED:    rgb = '{red: 8'd255, green: rise,   blue: 8'd0};
			jset_pkg::SEC_YELLOW: rgb = '{red: fall,   green: 8'd255, blue: 8'd0};
			jset_pkg::SEC_GREEN:  rgb = '{red: 8'd0,   green: 8'd255, blue: rise};
			jset_pkg::SEC_CYAN:   rgb = '{red: 8'd0,   green: fall,   blue: 8'd255};
			jset_pkg::SEC_BLUE:   rgb = '{red: rise,   green: 8'd0,   blue: 8'd255};
			default:              rgb = '{red: 8'd255, green: 8'd0,   blue: fall};
		endcase
	end

endmodule

// ----- src/julia_set_escape_time_unit.sv -----
// Top level: sequencer and datapath for one Julia set pixel at a time.
//
//  channel   signals                                 direction  carries
//  req       req_valid, req_ready, req_data          in         grid column and row
//  rsp       rsp_valid, rsp_ready, rsp_data          out        colour, count, bounded flag
//  cfg       cfg_valid, cfg_ready, cfg_index, cfg_data in       register writes
//
// From the accepting edge, the sequencer passes MAP and START, then loops SQUARE
// and TEST until the pixel escapes or its count reaches the limit. An escaped pixel
// then reduces its hue in HUE; FIN loads the result and IDLE takes the next pixel.
// Each pass of the loop multiplies, then compares and updates, through the shared
// multiply unit. Asynchronous reset loads the register defaults and idles the
// sequencer. A stalled result holds in the output register while the next pixel
// is accepted; the sequencer waits only if that register is full.
module julia_set_escape_time_unit (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           req_valid,
	output logic                           req_ready,
	input  jset_pkg::jset_req_t            req_data,
	output logic                           rsp_valid,
	input  logic                           rsp_ready,
	output jset_pkg::jset_rsp_t            rsp_data,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [jset_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]                    cfg_data
);

	jset_pkg::jset_cfg_t      cfg;
	jset_pkg::jset_mul_ops_t  ops;
	jset_pkg::jset_mul_prod_t prod;
	jset_pkg::jset_rgb_t      rgb;

	jset_pkg::jset_state_t    state_q, state_d;
	jset_pkg::jset_sector_t   s_q;

	logic [jset_pkg::IDX_W-1:0]      col_q, row_q, col_clamp, row_clamp;
	logic signed [31:0]              zr_q, zi_q;
	logic [jset_pkg::COUNT_BITS-1:0] k_q, limit;
	logic [jset_pkg::HUE_W-1:0]      h_q;
	logic                            bnd_q;
	jset_pkg::jset_rsp_t             rsp_q;
	logic                            rsp_valid_q;
	logic                            rsp_load;

	logic [63:0]        mag, bound;
	logic signed [63:0] diff;
	logic [31:0]        re_next, im_next, re_start, im_start;
	logic               escape;

	assign cfg_ready = 1'b1;

	jset_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	jset_cmul u_cmul (
		.clk  (clk),
		.ops  (ops),
		.prod (prod)
	);

	jset_hue u_hue (
		.sector (s_q),
		.frac   (h_q[5:0]),
		.rgb    (rgb)
	);

	// Saturate indexes beyond the grid
	assign col_clamp = (32'(req_data.column_index) >= jset_pkg::GRID_SIZE) ?
		jset_pkg::GRID_LAST : req_data.column_index;
	assign row_clamp = (32'(req_data.row_index) >= jset_pkg::GRID_SIZE) ?
		jset_pkg::GRID_LAST : req_data.row_index;

	assign limit = jset_pkg::COUNT_BITS'(cfg.iteration_limit);

	// Feed the multiply unit: grid mapping first, then the complex square
	always_comb begin
		if (state_q == jset_pkg::ST_MAP) begin
			ops.a0 = $signed(32'(col_q));
			ops.b0 = $signed({1'b0, cfg.real_step});
			ops.a1 = $signed(32'(row_q));
			ops.b1 = $signed({1'b0, cfg.imag_step});
			ops.a2 = '0;
			ops.b2 = '0;
		end else begin
			ops.a0 = zr_q;
			ops.b0 = zr_q;
			ops.a1 = zi_q;
			ops.b1 = zi_q;
			ops.a2 = zr_q;
			ops.b2 = zi_q;
		end
	end

	// Start point, escape test and next z from the registered products
	assign re_start = cfg.real_start + prod.p0[31:0];
	assign im_start = cfg.imag_start + prod.p1[31:0];
	assign mag      = prod.p0 + prod.p1;
	assign bound    = 64'(cfg.escape_limit) << jset_pkg::FRAC_BITS;
	assign escape   = mag > bound;
	assign diff     = prod.p0 - prod.p1;
	assign re_next  = diff[jset_pkg::FRAC_BITS+31:jset_pkg::FRAC_BITS] + cfg.c_real;
	assign im_next  = prod.p2[jset_pkg::FRAC_BITS+30:jset_pkg::FRAC_BITS-1] + cfg.c_imag;

	// Hold the sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= jset_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Advance the sequencer
	always_comb begin
		state_d   = state_q;
		req_ready = 1'b0;
		rsp_load  = 1'b0;
		unique case (state_q)
			jset_pkg::ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) state_d = jset_pkg::ST_MAP;
			end
			jset_pkg::ST_MAP:   state_d = jset_pkg::ST_START;
			jset_pkg::ST_START: state_d = jset_pkg::ST_SQUARE;
			jset_pkg::ST_SQUARE: begin
				if (k_q >= limit) state_d = jset_pkg::ST_FIN;
				else state_d = jset_pkg::ST_TEST;
			end
			jset_pkg::ST_TEST: begin
				if (escape) state_d = jset_pkg::ST_HUE;
				else state_d = jset_pkg::ST_SQUARE;
			end
			jset_pkg::ST_HUE: begin
				if (h_q < jset_pkg::HUE_SECTOR) state_d = jset_pkg::ST_FIN;
			end
			jset_pkg::ST_FIN: begin
				if (!rsp_valid_q || rsp_ready) begin
					rsp_load = 1'b1;
					state_d  = jset_pkg::ST_IDLE;
				end
			end
			default: state_d = jset_pkg::ST_IDLE;
		endcase
	end

	// Iterate z, count squarings and reduce the hue
	always_ff @(posedge clk) begin
		unique case (state_q)
			jset_pkg::ST_IDLE: begin
				col_q <= col_clamp;
				row_q <= row_clamp;
				k_q   <= '0;
			end
			jset_pkg::ST_START: begin
				zr_q <= re_start;
				zi_q <= im_start;
			end
			jset_pkg::ST_SQUARE: begin
				bnd_q <= 1'b1;
			end
			jset_pkg::ST_TEST: begin
				bnd_q <= 1'b0;
				h_q   <= jset_pkg::HUE_W'(k_q);
				s_q   <= jset_pkg::SEC_RED;
				if (!escape) begin
					zr_q <= re_next;
					zi_q <= im_next;
					k_q  <= k_q + 1'b1;
				end
			end
			jset_pkg::ST_HUE: begin
				priority if (h_q >= jset_pkg::HUE_TURN) begin
					h_q <= h_q - jset_pkg::HUE_TURN;
				end else if (h_q >= jset_pkg::HUE_SECTOR) begin
					h_q <= h_q - jset_pkg::HUE_SECTOR;
					s_q <= jset_pkg::jset_sector_t'(s_q + 3'd1);
				end else begin
					h_q <= h_q;
				end
			end
			default: ;
		endcase
	end

	// Hold the result until the transaction completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (rsp_load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_load) begin
			rsp_q.red             <= bnd_q ? 8'd0 : rgb.red;
			rsp_q.green           <= bnd_q ? 8'd0 : rgb.green;
			rsp_q.blue            <= bnd_q ? 8'd0 : rgb.blue;
			rsp_q.iteration_count <= 10'(k_q);
			rsp_q.bounded         <= bnd_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;

endmodule

// ----- src/jset_checker.sv -----
// Port-level checks on the Julia set escape-time unit, bound to the top level.
module jset_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                req_valid,
	input logic                req_ready,
	input logic                rsp_valid,
	input logic                rsp_ready,
	input jset_pkg::jset_rsp_t rsp_data
);

	// Drop a stalled result never and keep it unchanged
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
		else $error("result changed or dropped while stalled");

	// Work on one pixel at a time
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("new pixel taken while one is in work");

	// Colour a bounded pixel black
	a_bounded_black: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_data.bounded |->
			rsp_data.red == 8'd0 && rsp_data.green == 8'd0 && rsp_data.blue == 8'd0)
		else $error("bounded pixel not black");

	// Keep an escaped colour at full value with one channel dark
	a_escaped_hsv: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_data.bounded |->
			(rsp_data.red == 8'd255 || rsp_data.green == 8'd255 || rsp_data.blue == 8'd255) &&
			(rsp_data.red == 8'd0 || rsp_data.green == 8'd0 || rsp_data.blue == 8'd0))
		else $error("escaped colour off the hue circle");

endmodule

bind julia_set_escape_time_unit jset_checker u_jset_checker (.*);

// ----- sim/tb_top.sv -----
// Self-checking testbench for the Julia set escape-time unit.
module tb_top;

	localparam int RANDOM_ITEMS = 830;
	localparam int DRAIN_CYCLES = 2 * 1023 + 16;
	// every item at the full count with the longest gaps on both sides, taken four times over
	localparam int CYCLE_LIMIT = 920 * (2 * 1023 + 5 + 7 + 14 + 14) * 4;
	localparam logic [jset_pkg::CFG_IDX_W-1:0] CFG_SPARE_FIRST = jset_pkg::CFG_IMAG_STEP + 1;
	localparam logic [jset_pkg::CFG_IDX_W-1:0] CFG_SPARE_LAST = (1 << jset_pkg::CFG_IDX_W) - 1;
	localparam logic [7:0] FULL = 8'hFF;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	jset_pkg::jset_req_t req_data = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	jset_pkg::jset_rsp_t rsp_data;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [jset_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;

	jset_pkg::jset_cfg_t cfg_shadow;
	jset_pkg::jset_rsp_t pixel_expected[$];
	jset_pkg::jset_rsp_t colour_due;
	int fail_count = 0;
	int cycle_count = 0;
	logic idle_on = 1'b1;
	int rsp_hold_left = 0;
	int rsp_stall_left = 0;

	julia_set_escape_time_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req_data (req_data),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp_data (rsp_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always #5 clk = ~clk;

	// Abort on a hung run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// Work out the colour, count and bounded flag of one grid point
	function automatic jset_pkg::jset_rsp_t pixel_colour(input jset_pkg::jset_req_t px);
		logic [jset_pkg::IDX_W-1:0] col, row;
		logic signed [31:0] zr, zi;
		longint re, im, rr, ii, ri;
		logic [63:0] mag, limit_sq;
		int unsigned lim, k, hue, frac, rise, fall;
		jset_pkg::jset_rsp_t r;
		col = (px.column_index >= jset_pkg::GRID_SIZE) ? jset_pkg::GRID_LAST : px.column_index;
		row = (px.row_index >= jset_pkg::GRID_SIZE) ? jset_pkg::GRID_LAST : px.row_index;
		lim = cfg_shadow.iteration_limit;
		limit_sq = 64'(cfg_shadow.escape_limit) << jset_pkg::FRAC_BITS;
		zr = 32'(longint'($signed(cfg_shadow.real_start))
			+ longint'(col) * longint'(cfg_shadow.real_step));
		zi = 32'(longint'($signed(cfg_shadow.imag_start))
			+ longint'(row) * longint'(cfg_shadow.imag_step));
		for (k = 0; k < lim; k++) begin
			re = zr;
			im = zi;
			rr = re * re;
			ii = im * im;
			ri = re * im;
			mag = rr + ii;
			if (mag > limit_sq)
				break;
			zr = 32'(((rr - ii) >>> jset_pkg::FRAC_BITS)
				+ longint'($signed(cfg_shadow.c_real)));
			zi = 32'((ri >>> (jset_pkg::FRAC_BITS - 1))
				+ longint'($signed(cfg_shadow.c_imag)));
		end
		r = '0;
		r.iteration_count = 10'(k);
		r.bounded = (k >= lim);
		if (!r.bounded) begin
			hue = k % jset_pkg::HUE_TURN;
			frac = hue % jset_pkg::HUE_SECTOR;
			rise = 255 * frac / jset_pkg::HUE_SECTOR;
			fall = 255 * (jset_pkg::HUE_SECTOR - frac) / jset_pkg::HUE_SECTOR;
			case (jset_pkg::jset_sector_t'(hue / jset_pkg::HUE_SECTOR))
				jset_pkg::SEC_RED: begin
					r.red = FULL;
					r.green = 8'(rise);
				end
				jset_pkg::SEC_YELLOW: begin
					r.red = 8'(fall);
					r.green = FULL;
				end
				jset_pkg::SEC_GREEN: begin
					r.green = FULL;
					r.blue = 8'(rise);
				end
				jset_pkg::SEC_CYAN: begin
					r.green = 8'(fall);
					r.blue = FULL;
				end
				jset_pkg::SEC_BLUE: begin
					r.red = 8'(rise);
					r.blue = FULL;
				end
				default: begin
					r.red = FULL;
					r.blue = 8'(fall);
				end
			endcase
		end
		return r;
	endfunction

	// Mostly uniform grid positions, now and then an edge of the grid
	function automatic logic [jset_pkg::IDX_W-1:0] random_index();
		if ($urandom_range(0, 7) == 0)
			return $urandom_range(0, 1) ? jset_pkg::GRID_LAST : '0;
		return jset_pkg::IDX_W'($urandom_range(0, jset_pkg::GRID_SIZE - 1));
	endfunction

	// A view of the plane around the set, with both parts of c between -1 and 1
	function automatic jset_pkg::jset_cfg_t pick_view();
		jset_pkg::jset_cfg_t c;
		c.c_real = 32'(int'($urandom_range(0, 1 << 29)) - (1 << 28));
		c.c_imag = 32'(int'($urandom_range(0, 1 << 29)) - (1 << 28));
		c.iteration_limit = jset_pkg::RST_ITER_LIMIT;
		c.escape_limit = 31'($urandom_range(1 << 28, 32'h7FFF_FFFF));
		c.real_start = 32'(-int'($urandom_range(1 << 28, 1 << 29)));
		c.real_step = 31'($urandom_range(1 << 20, 1 << 21));
		c.imag_start = 32'(-int'($urandom_range(1 << 28, 1 << 29)));
		c.imag_step = 31'($urandom_range(1 << 20, 1 << 21));
		return c;
	endfunction

	function automatic jset_pkg::jset_cfg_t pick_noise();
		jset_pkg::jset_cfg_t c;
		c.c_real = $urandom();
		c.c_imag = $urandom();
		c.iteration_limit = jset_pkg::RST_ITER_LIMIT;
		c.escape_limit = 31'($urandom());
		c.real_start = $urandom();
		c.real_step = 31'($urandom());
		c.imag_start = $urandom();
		c.imag_step = 31'($urandom());
		return c;
	endfunction

	// Drop the request and hold until every result is back
	task automatic wait_drained();
		req_valid = 1'b0;
		while (pixel_expected.size() != 0)
			@(negedge clk);
	endtask

	// Offer one grid point and record its expected result once taken
	task automatic send_pixel(input logic [jset_pkg::IDX_W-1:0] col,
		input logic [jset_pkg::IDX_W-1:0] row);
		int gap;
		if (idle_on && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 14);
			req_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_data.column_index = col;
		req_data.row_index = row;
		req_valid = 1'b1;
		do @(posedge clk); while (!req_ready);
		pixel_expected.push_back(pixel_colour(req_data));
		@(negedge clk);
	endtask

	// Write one register while the unit is idle; cfg_valid is left high
	task automatic write_reg(input logic [jset_pkg::CFG_IDX_W-1:0] idx,
		input logic [31:0] value);
		wait_drained();
		cfg_index = idx;
		cfg_data = value;
		cfg_valid = 1'b1;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			jset_pkg::CFG_C_REAL:       cfg_shadow.c_real = value;
			jset_pkg::CFG_C_IMAG:       cfg_shadow.c_imag = value;
			jset_pkg::CFG_ITER_LIMIT:   cfg_shadow.iteration_limit = value[9:0];
			jset_pkg::CFG_ESCAPE_LIMIT: cfg_shadow.escape_limit = value[30:0];
			jset_pkg::CFG_REAL_START:   cfg_shadow.real_start = value;
			jset_pkg::CFG_REAL_STEP:    cfg_shadow.real_step = value[30:0];
			jset_pkg::CFG_IMAG_START:   cfg_shadow.imag_start = value;
			jset_pkg::CFG_IMAG_STEP:    cfg_shadow.imag_step = value[30:0];
			default: ;
		endcase
		@(negedge clk);
	endtask

	// Load all eight registers; unused upper bits carry junk
	task automatic load_config(input jset_pkg::jset_cfg_t c);
		write_reg(jset_pkg::CFG_C_REAL, c.c_real);
		write_reg(jset_pkg::CFG_C_IMAG, c.c_imag);
		write_reg(jset_pkg::CFG_ITER_LIMIT, {22'($urandom()), c.iteration_limit});
		write_reg(jset_pkg::CFG_ESCAPE_LIMIT, {1'($urandom()), c.escape_limit});
		write_reg(jset_pkg::CFG_REAL_START, c.real_start);
		write_reg(jset_pkg::CFG_REAL_STEP, {1'($urandom()), c.real_step});
		write_reg(jset_pkg::CFG_IMAG_START, c.imag_start);
		write_reg(jset_pkg::CFG_IMAG_STEP, {1'($urandom()), c.imag_step});
		if ($urandom_range(0, 3) == 0)
			write_reg(jset_pkg::CFG_IDX_W'($urandom_range(CFG_SPARE_FIRST, CFG_SPARE_LAST)),
				$urandom());
		cfg_valid = 1'b0;
	endtask

	// Result side: random stall bursts, plus a long hold-off on request
	always @(negedge clk) begin
		if (rsp_hold_left > 0) begin
			rsp_ready = 1'b0;
			rsp_hold_left--;
		end else if (rsp_stall_left > 0) begin
			rsp_ready = 1'b0;
			rsp_stall_left--;
		end else if (idle_on && $urandom_range(0, 9) == 0) begin
			rsp_stall_left = $urandom_range(1, 14) - 1;
			rsp_ready = 1'b0;
		end else begin
			rsp_ready = 1'b1;
		end
	end

	// Compare each result transaction with the oldest expectation
	always @(posedge clk) begin
		if (arst_n && rsp_valid && rsp_ready) begin
			if (pixel_expected.size() == 0) begin
				$error("result with none pending: %p", rsp_data);
				fail_count++;
			end else begin
				colour_due = pixel_expected.pop_front();
				if (rsp_data.red !== colour_due.red) begin
					$error("red: expected %0d, got %0d", colour_due.red, rsp_data.red);
					fail_count++;
				end
				if (rsp_data.green !== colour_due.green) begin
					$error("green: expected %0d, got %0d", colour_due.green, rsp_data.green);
					fail_count++;
				end
				if (rsp_data.blue !== colour_due.blue) begin
					$error("blue: expected %0d, got %0d", colour_due.blue, rsp_data.blue);
					fail_count++;
				end
				if (rsp_data.iteration_count !== colour_due.iteration_count) begin
					$error("iteration_count: expected %0d, got %0d",
						colour_due.iteration_count, rsp_data.iteration_count);
					fail_count++;
				end
				if (rsp_data.bounded !== colour_due.bounded) begin
					$error("bounded: expected %0d, got %0d", colour_due.bounded,
						rsp_data.bounded);
					fail_count++;
				end
			end
		end
	end

	// Corners and centre of the grid under the reset view
	task automatic test_reset_view();
		send_pixel('0, '0);
		send_pixel(jset_pkg::GRID_LAST, jset_pkg::GRID_LAST);
		send_pixel(jset_pkg::GRID_LAST, '0);
		send_pixel('0, jset_pkg::GRID_LAST);
		send_pixel(jset_pkg::IDX_W'(jset_pkg::GRID_SIZE / 2),
			jset_pkg::IDX_W'(jset_pkg::GRID_SIZE / 2));
	endtask

	task automatic test_register_extremes();
		jset_pkg::jset_cfg_t c;
		// zero iteration limit: black, count zero
		c = cfg_shadow;
		c.iteration_limit = '0;
		load_config(c);
		send_pixel('0, '0);
		send_pixel(jset_pkg::GRID_LAST, jset_pkg::GRID_LAST);
		// one iteration, zero escape bound, origin at column and row zero
		c.iteration_limit = 10'd1;
		c.escape_limit = '0;
		c.real_start = '0;
		c.imag_start = '0;
		load_config(c);
		send_pixel('0, '0);
		send_pixel(jset_pkg::GRID_LAST, '0);
		// largest constant, starts and steps: start points and z wrap
		c = '{c_real: 32'sh7FFF_FFFF, c_imag: 32'sh7FFF_FFFF, iteration_limit: 10'h3FF,
			escape_limit: 31'h7FFF_FFFF, real_start: 32'sh7FFF_FFFF,
			real_step: 31'h7FFF_FFFF, imag_start: 32'sh7FFF_FFFF,
			imag_step: 31'h7FFF_FFFF};
		load_config(c);
		send_pixel(jset_pkg::GRID_LAST, jset_pkg::GRID_LAST);
		send_pixel('0, jset_pkg::GRID_LAST);
		send_pixel(jset_pkg::IDX_W'(1), jset_pkg::IDX_W'(2));
		// most negative constant and starts, zero steps
		c = '{c_real: 32'sh8000_0000, c_imag: 32'sh8000_0000, iteration_limit: 10'd64,
			escape_limit: 31'h7FFF_FFFF, real_start: 32'sh8000_0000, real_step: '0,
			imag_start: 32'sh8000_0000, imag_step: '0};
		load_config(c);
		send_pixel('0, '0);
		send_pixel(jset_pkg::GRID_LAST, jset_pkg::GRID_LAST);
		// z pinned at zero: bounded at the full count
		c = '{c_real: '0, c_imag: '0, iteration_limit: 10'h3FF, escape_limit: 31'h7FFF_FFFF,
			real_start: '0, real_step: '0, imag_start: '0, imag_step: '0};
		load_config(c);
		send_pixel(jset_pkg::GRID_LAST, '0);
		// spare register index: settings must stay as they are
		write_reg(CFG_SPARE_FIRST, $urandom());
		write_reg(CFG_SPARE_LAST, $urandom());
		cfg_valid = 1'b0;
		send_pixel('0, '0);
		send_pixel(jset_pkg::GRID_LAST, jset_pkg::GRID_LAST);
		req_valid = 1'b0;
	endtask

	// Phases of random settings, each followed by a batch of grid points
	task automatic test_random_views();
		jset_pkg::jset_cfg_t c;
		int sent, batch, sel;
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			c = ($urandom_range(0, 4) == 0) ? pick_noise() : pick_view();
			sel = $urandom_range(0, 19);
			if (sel == 0) begin
				c.iteration_limit = '0;
				batch = 6;
			end else if (sel == 1) begin
				c.iteration_limit = 10'h3FF;
				batch = 3;
			end else if (sel < 8) begin
				c.iteration_limit = 10'($urandom_range(151, 500));
				batch = $urandom_range(15, 30);
			end else begin
				c.iteration_limit = 10'($urandom_range(1, 150));
				batch = $urandom_range(20, 40);
			end
			load_config(c);
			idle_on = ($urandom_range(0, 3) != 0);
			repeat (batch) send_pixel(random_index(), random_index());
			sent += batch;
		end
		idle_on = 1'b1;
		req_valid = 1'b0;
	endtask

	// Hold results off long enough to stall the input, then pause the sender
	task automatic test_output_backpressure();
		jset_pkg::jset_cfg_t c;
		c = pick_view();
		c.iteration_limit = 10'd8;
		load_config(c);
		rsp_hold_left = 400;
		repeat (8) send_pixel(random_index(), random_index());
		wait_drained();
		repeat (4) send_pixel(random_index(), random_index());
		req_valid = 1'b0;
	endtask

	// Back-to-back transactions with no idling on either side
	task automatic test_steady_stream();
		jset_pkg::jset_cfg_t c;
		idle_on = 1'b0;
		c = pick_view();
		c.iteration_limit = 10'd40;
		load_config(c);
		repeat (40) send_pixel(random_index(), random_index());
		req_valid = 1'b0;
	endtask

	initial begin
		cfg_shadow = '{c_real: jset_pkg::RST_C_REAL, c_imag: jset_pkg::RST_C_IMAG,
			iteration_limit: jset_pkg::RST_ITER_LIMIT, escape_limit: jset_pkg::RST_ESCAPE,
			real_start: jset_pkg::RST_REAL_START, real_step: jset_pkg::RST_REAL_STEP,
			imag_start: jset_pkg::RST_IMAG_START, imag_step: jset_pkg::RST_IMAG_STEP};
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_reset_view();
		test_register_extremes();
		test_output_backpressure();
		test_random_views();
		test_steady_stream();
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
